// ----- hdl/ihex_pkg.sv -----
// Shared types and constants for the Intel HEX segment loader.
`timescale 1ns / 1ps
package ihex_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] character;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] address;
    logic [7:0]  byte_value;
    logic [9:0]  segment_length;
    logic        external;
    logic [2:0]  error_code;
    logic        last;
  } out_item_t;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NOT_RECORD = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE   = 3'd1;
  localparam logic [2:0] ERR_TOO_SHORT  = 3'd2;
  localparam logic [2:0] ERR_EXT_REFUSE = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd5;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  localparam logic REG_CHIP_VARIANT   = 1'b0;
  localparam logic REG_ALLOW_EXTERNAL = 1'b1;

  localparam logic [1:0] CHIP_FX2LP = 2'd0;
  localparam logic [1:0] CHIP_FX2   = 2'd1;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  localparam logic [9:0] RECORD_OVERHEAD = 10'd11;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_COMMENT,
    MODE_RECORD
  } line_mode_t;

  typedef enum logic [1:0] {
    EMIT_ERROR,
    EMIT_CLOSE,
    EMIT_FINISH,
    EMIT_DATA
  } emit_sel_t;

  typedef struct packed {
    logic       load;
    logic       set_comment;
    logic       set_record;
    logic       set_start;
    logic       take_char;
    logic       check;
    logic       seg_merge;
    logic       emit;
    emit_sel_t  emit_sel;
    logic       emit_last;
    logic [2:0] err_code;
    logic       idx_clear;
    logic       idx_inc;
  } ihex_cmd_t;

  typedef struct packed {
    logic       finished;
    logic       eof;
    line_mode_t mode;
    logic       is_hash;
    logic       is_colon;
    logic       is_newline;
    logic       pos_full;
    logic       fault;
    logic       type_eof;
    logic       type_bad;
    logic       len_big;
    logic       too_short;
    logic       need_close;
    logic       len_zero;
    logic       wlen_zero;
    logic       refused;
    logic       idx_last;
    logic       out_free;
  } ihex_status_t;

  // Does a segment reach outside internal RAM for the chosen chip
  function automatic logic seg_external(input logic [1:0] variant,
                                        input logic [15:0] a,
                                        input logic [9:0] len);
    logic [16:0] e;
    e = {1'b0, a} + {7'd0, len};
    if (variant == CHIP_FX2LP) begin
      if (a <= 16'h3fff) return e > 17'h04000;
      if (a >= 16'he000 && a <= 16'he1ff) return e > 17'h0e200;
      return 1'b1;
    end
    if (variant == CHIP_FX2) begin
      if (a <= 16'h1fff) return e > 17'h02000;
      if (a >= 16'he000 && a <= 16'he1ff) return e > 17'h0e200;
      return 1'b1;
    end
    if (a <= 16'h1b3f) return e > 17'h01b40;
    return 1'b1;
  endfunction

endpackage

// ----- hdl/ihex_dpath.sv -----
// Datapath: line parser registers, record buffer, segment tracking, output register.
`timescale 1ns / 1ps
module ihex_dpath #(
  parameter int MAX_RECORD_BYTES = 16,
  parameter int SEGMENT_BYTES    = 1023,
  parameter int LINE_CHARS       = 511
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ihex_pkg::in_item_t   in_item,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [1:0]           cfg_data,
  input  ihex_pkg::ihex_cmd_t  cmd,
  output ihex_pkg::ihex_status_t st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihex_pkg::out_item_t  out_item
);
  import ihex_pkg::*;

  localparam int IW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
  localparam int CW = $clog2(MAX_RECORD_BYTES + 1);

  logic [1:0]  chip_variant;
  logic        allow_external;
  in_item_t    item;
  logic [8:0]  line_position;
  line_mode_t  line_mode;
  logic [7:0]  record_length;
  logic [15:0] record_offset;
  logic [7:0]  record_type;
  logic [3:0]  hex_nibble;
  logic        hex_fault;
  logic [7:0]  record_bytes [MAX_RECORD_BYTES];
  logic [15:0] segment_start;
  logic [9:0]  segment_count;
  logic        finished;
  logic [7:0]  work_length;
  logic [15:0] work_offset;
  logic [CW-1:0] idx;
  logic [7:0]  rd_data;

  logic [3:0]  nib;
  logic        bad;
  logic [8:0]  d;
  logic [7:0]  didx;
  logic        ext_c;
  logic        refused;
  logic [16:0] seg_end;
  logic [10:0] seg_sum;
  logic        mem_we;
  out_item_t   emit_item;

  always_comb begin
    bad = 1'b0;
    nib = 4'd0;
    if (item.character >= 8'h30 && item.character <= 8'h39) begin
      nib = 4'(item.character - 8'h30);
    end else if (item.character >= 8'h41 && item.character <= 8'h46) begin
      nib = 4'(item.character - 8'h37);
    end else if (item.character >= 8'h61 && item.character <= 8'h66) begin
      nib = 4'(item.character - 8'h57);
    end else begin
      bad = 1'b1;
    end
  end

  assign d       = line_position - 9'd9;
  assign didx    = d[8:1];
  assign mem_we  = cmd.take_char && line_position > 9'd8 && didx < record_length && d[0]
                   && {1'b0, didx} < 9'(MAX_RECORD_BYTES);
  assign ext_c   = (segment_count != 10'd0)
                   && seg_external(chip_variant, segment_start, segment_count);
  assign refused = ext_c && !allow_external;
  assign seg_end = {1'b0, segment_start} + {7'd0, segment_count};
  assign seg_sum = {1'b0, segment_count} + {3'd0, record_length};

  always_comb begin
    st.finished   = finished;
    st.eof        = item.command == CMD_EOF;
    st.mode       = line_mode;
    st.is_hash    = item.character == CH_HASH;
    st.is_colon   = item.character == CH_COLON;
    st.is_newline = item.character == CH_NEWLINE;
    st.pos_full   = line_position >= 9'(LINE_CHARS);
    st.fault      = hex_fault;
    st.type_eof   = record_type == REC_EOF;
    st.type_bad   = record_type != REC_DATA && record_type != REC_EOF;
    st.len_big    = record_length > 8'(MAX_RECORD_BYTES);
    st.too_short  = {1'b0, record_length, 1'b0} + RECORD_OVERHEAD > {1'b0, line_position};
    st.need_close = segment_count != 10'd0
                    && ({1'b0, record_offset} != seg_end
                        || seg_sum > 11'(SEGMENT_BYTES));
    st.len_zero   = record_length == 8'd0;
    st.wlen_zero  = work_length == 8'd0;
    st.refused    = refused;
    st.idx_last   = 8'(idx) == work_length - 8'd1;
    st.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    emit_item = '0;
    emit_item.last = cmd.emit_last;
    case (cmd.emit_sel)
      EMIT_ERROR: begin
        emit_item.kind       = KIND_ERROR;
        emit_item.error_code = cmd.err_code;
      end
      EMIT_CLOSE, EMIT_FINISH: begin
        emit_item.address        = {1'b0, segment_start};
        emit_item.segment_length = segment_count;
        emit_item.external       = ext_c;
        if (refused) begin
          emit_item.kind       = KIND_ERROR;
          emit_item.error_code = ERR_EXT_REFUSE;
        end else begin
          emit_item.kind = (cmd.emit_sel == EMIT_CLOSE) ? KIND_CLOSED : KIND_DONE;
        end
      end
      EMIT_DATA: begin
        emit_item.kind       = KIND_DATA;
        emit_item.address    = {1'b0, work_offset} + 17'(idx);
        emit_item.byte_value = rd_data;
      end
      default: emit_item = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      record_bytes[didx[IW-1:0]] <= {hex_nibble, nib};
    end
    rd_data <= record_bytes[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_variant   <= 2'd0;
      allow_external <= 1'b0;
      line_position  <= 9'd0;
      line_mode      <= MODE_START;
      record_length  <= 8'd0;
      record_offset  <= 16'd0;
      record_type    <= 8'd0;
      hex_nibble     <= 4'd0;
      hex_fault      <= 1'b0;
      segment_start  <= 16'd0;
      segment_count  <= 10'd0;
      finished       <= 1'b0;
      work_length    <= 8'd0;
      work_offset    <= 16'd0;
      idx            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CHIP_VARIANT) chip_variant <= cfg_data;
        else allow_external <= cfg_data[0];
      end
      if (cmd.load) item <= in_item;
      if (cmd.set_comment) line_mode <= MODE_COMMENT;
      if (cmd.set_start) line_mode <= MODE_START;
      if (cmd.set_record) begin
        line_mode     <= MODE_RECORD;
        line_position <= 9'd1;
      end
      if (cmd.take_char) begin
        line_position <= line_position + 9'd1;
        if (line_position <= 9'd2) begin
          if (bad) hex_fault <= 1'b1;
          record_length <= {record_length[3:0], nib};
        end else if (line_position <= 9'd6) begin
          if (bad) hex_fault <= 1'b1;
          record_offset <= {record_offset[11:0], nib};
        end else if (line_position <= 9'd8) begin
          if (bad) hex_fault <= 1'b1;
          record_type <= {record_type[3:0], nib};
        end else if (didx < record_length) begin
          if (bad) hex_fault <= 1'b1;
          if (!d[0]) hex_nibble <= nib;
        end
      end
      if (cmd.check) begin
        // latch the record, then clear the line
        work_length   <= record_length;
        work_offset   <= record_offset;
        line_position <= 9'd0;
        line_mode     <= MODE_START;
        record_length <= 8'd0;
        record_offset <= 16'd0;
        record_type   <= 8'd0;
        hex_nibble    <= 4'd0;
        hex_fault     <= 1'b0;
      end
      if (cmd.seg_merge) begin
        segment_count <= segment_count + 10'(record_length);
        if (segment_count == 10'd0) segment_start <= record_offset;
      end
      if (cmd.idx_clear) idx <= '0;
      if (cmd.idx_inc) idx <= idx + 1'b1;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_item  <= emit_item;
        case (cmd.emit_sel)
          EMIT_ERROR, EMIT_FINISH: finished <= 1'b1;
          EMIT_CLOSE: begin
            if (refused) begin
              finished <= 1'b1;
            end else begin
              segment_count <= 10'(work_length);
              segment_start <= work_offset;
            end
          end
          default: ;
        endcase
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/ihex_ctrl.sv -----
// Controller: sequences each item through parsing, record checks and result emission.
`timescale 1ns / 1ps
module ihex_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ihex_pkg::ihex_status_t st,
  output ihex_pkg::ihex_cmd_t    cmd
);
  import ihex_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_CHECK, S_CLOSE, S_READ, S_DATA, S_FINISH, S_ERROR
  } state_t;

  state_t     state, state_next;
  logic [2:0] err_code, err_code_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next    = state;
    err_code_next = err_code;
    cmd           = '0;
    cmd.err_code  = err_code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (!st.finished) begin
          if (st.eof) begin
            state_next = (st.mode == MODE_RECORD) ? S_CHECK : S_FINISH;
          end else begin
            case (st.mode)
              MODE_START: begin
                if (st.is_hash) cmd.set_comment = 1'b1;
                else if (st.is_colon) cmd.set_record = 1'b1;
                else begin
                  err_code_next = ERR_NOT_RECORD;
                  state_next    = S_ERROR;
                end
              end
              MODE_COMMENT: begin
                if (st.is_newline) cmd.set_start = 1'b1;
              end
              default: begin
                if (st.is_newline) state_next = S_CHECK;
                else if (st.pos_full) begin
                  err_code_next = ERR_TOO_LONG;
                  state_next    = S_ERROR;
                end else cmd.take_char = 1'b1;
              end
            endcase
          end
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (st.fault) begin
          err_code_next = ERR_BAD_HEX;
          state_next    = S_ERROR;
        end else if (st.type_eof) begin
          state_next = S_FINISH;
        end else if (st.type_bad) begin
          err_code_next = ERR_BAD_TYPE;
          state_next    = S_ERROR;
        end else if (st.len_big) begin
          err_code_next = ERR_TOO_LONG;
          state_next    = S_ERROR;
        end else if (st.too_short) begin
          err_code_next = ERR_TOO_SHORT;
          state_next    = S_ERROR;
        end else if (st.need_close) begin
          state_next = S_CLOSE;
        end else begin
          cmd.seg_merge = 1'b1;
          cmd.idx_clear = 1'b1;
          if (!st.len_zero) state_next = S_READ;
          else state_next = st.eof ? S_FINISH : S_IDLE;
        end
      end
      S_CLOSE: begin
        cmd.emit_sel  = EMIT_CLOSE;
        cmd.emit_last = st.refused || (st.wlen_zero && !st.eof);
        cmd.idx_clear = 1'b1;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.refused) state_next = S_IDLE;
          else if (!st.wlen_zero) state_next = S_READ;
          else state_next = st.eof ? S_FINISH : S_IDLE;
        end
      end
      S_READ: state_next = S_DATA;
      S_DATA: begin
        cmd.emit_sel  = EMIT_DATA;
        cmd.emit_last = st.idx_last && !st.eof;
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.idx_inc = 1'b1;
          if (!st.idx_last) state_next = S_READ;
          else state_next = st.eof ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        cmd.emit_sel  = EMIT_FINISH;
        cmd.emit_last = 1'b1;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERROR: begin
        cmd.emit_sel  = EMIT_ERROR;
        cmd.emit_last = 1'b1;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      err_code <= ERR_NOT_RECORD;
    end else begin
      state    <= state_next;
      err_code <= err_code_next;
    end
  end

endmodule

// ----- hdl/intel_hex_segment_loader.sv -----
// Top level of the Intel HEX segment loader.
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_item (command, character)
//   out      output     out_valid / out_stall out_item (one result)
//   cfg      input      cfg_we                cfg_index, cfg_data
// An ordinary character is loaded, then decoded; a record end adds a check, a
// segment close or finish, and per data byte a record buffer read, then an emit.
// One item is processed at a time, set by the controller sequence.
// Reset is synchronous; output stalls hold the sequence at its next emission.
`timescale 1ns / 1ps
module intel_hex_segment_loader #(
  parameter int MAX_RECORD_BYTES = 16,
  parameter int SEGMENT_BYTES    = 1023,
  parameter int LINE_CHARS       = 511
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ihex_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ihex_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [1:0]          cfg_data
);
  import ihex_pkg::*;

  ihex_cmd_t    cmd;
  ihex_status_t st;

  ihex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ihex_dpath #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .SEGMENT_BYTES    (SEGMENT_BYTES),
    .LINE_CHARS       (LINE_CHARS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- hdl/ihex_checker.sv -----
// Port checker for the Intel HEX segment loader, bound to the top level.
`timescale 1ns / 1ps
module ihex_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ihex_pkg::out_item_t out_item
);
  import ihex_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // take the next item only after the current one is worked through
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted back to back");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_ERROR |-> out_item.error_code <= ERR_BAD_HEX)
    else $error("error code out of range");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_DATA
    |-> out_item.segment_length == 10'd0 && !out_item.external)
    else $error("data result carries segment fields");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind intel_hex_segment_loader ihex_checker u_ihex_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
